// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. All checks are clocked on clk_i and
// are switched off while rst_ni is low unless the _RST form is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("msfd assertion failed");
`define MSFD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("msfd assertion failed");
`else
`define MSFD_ASSERT(label, prop)
`define MSFD_ASSERT_RST(label, prop)
`endif
`endif

// ----- rtl/msfd_pkg.sv -----
package msfd_pkg;

  // Field widths of the request and result items
  localparam int TYPE_W   = 2;
  localparam int CHAN_W   = 5;
  localparam int SAMPLE_W = 24;
  localparam int DVAL_W   = 28;
  localparam int GAIN_W   = 24;
  localparam int SDLY_W   = 11;
  localparam int STEP_W   = 16;

  // APB register file
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_MAX_EXTRA  = 2'd0;
  localparam logic [1:0] REG_DELAY_STEP = 2'd1;
  localparam logic [1:0] REG_GAIN_STEP  = 2'd2;

  localparam logic [SDLY_W-1:0] MAX_EXTRA_RST  = 11'd1120;
  localparam logic [STEP_W-1:0] DELAY_STEP_RST = 16'd32768;
  localparam logic [STEP_W-1:0] GAIN_STEP_RST  = 16'd350;
  localparam logic [STEP_W-1:0] DSTEP_MAX      = 16'd32768;

  // Gain formats are Q2.22
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'h400000;
  localparam logic [GAIN_W-1:0] GAIN_MIN   = 24'h200000;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 24'h800000;
  localparam logic [SDLY_W-1:0] STATIC_DELAY_MAX = 11'd2047;

  typedef enum logic [TYPE_W-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TRIM   = 2'd1,
    REQ_TARGET = 2'd2
  } req_type_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHAN   = 6'b000010,
    ST_TAP0   = 6'b000100,
    ST_TAP1   = 6'b001000,
    ST_INTERP = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  typedef struct packed {
    logic [SDLY_W-1:0] max_extra_delay;
    logic [STEP_W-1:0] delay_slew_step;
    logic [STEP_W-1:0] gain_slew_step;
  } cfg_t;

  // One word of per-channel state
  typedef struct packed {
    logic [GAIN_W-1:0] static_gain;
    logic [SDLY_W-1:0] static_delay;
    logic [DVAL_W-1:0] extra_now;
    logic [DVAL_W-1:0] extra_goal;
    logic [GAIN_W-1:0] gain_now;
    logic [GAIN_W-1:0] gain_goal;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{
    static_gain:  UNITY_GAIN,
    static_delay: '0,
    extra_now:    '0,
    extra_goal:   '0,
    gain_now:     UNITY_GAIN,
    gain_goal:    UNITY_GAIN
  };

  // Saturate to signed 24 bits
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Move toward goal by at most one step, land exactly on it
  function automatic logic signed [29:0] glide(input logic signed [29:0] now,
                                               input logic signed [29:0] goal,
                                               input logic signed [29:0] step);
    if (now < goal - step) begin
      return now + step;
    end else if (now > goal + step) begin
      return now - step;
    end
    return goal;
  endfunction

endpackage

// ----- rtl/msfd_if.sv -----
// Request channel: one item per accepted transfer
interface msfd_req_if import msfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [TYPE_W-1:0]          req_type;
  logic [CHAN_W-1:0]          channel;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [DVAL_W-1:0]          delay_value;
  logic [GAIN_W-1:0]          gain_value;
  logic                       frame_end;

  modport source (
    output valid, req_type, channel, sample_in, delay_value, gain_value, frame_end,
    input  ready
  );
  modport sink (
    input  valid, req_type, channel, sample_in, delay_value, gain_value, frame_end,
    output ready
  );
endinterface

// Result channel
interface msfd_rsp_if import msfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CHAN_W-1:0]          out_channel;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_frame_end;

  modport source (
    output valid, out_channel, out_sample, out_frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_channel, out_sample, out_frame_end,
    output ready
  );
endinterface

// ----- rtl/multichannel_slewed_fractional_delay.sv -----
// Multichannel gain trim and fractional delay alignment. Each channel keeps a
// ring of RING_DEPTH samples (a power of two) in one shared RAM, and its trims
// and tracked delay/gain in a second RAM. Requests are handled one at a time:
// an audio sample steps through the CHAN, TAP0, TAP1, INTERP and OUT states
// (one channel-state read, two ring reads on the single read port with the new
// sample written alongside the second, then the interpolation and output
// multipliers, each registered) before it reaches the result register and the
// next request is taken; trim and target requests do a read-modify-write of
// the channel state in CHAN; requests that are ignored are accepted and
// dropped in IDLE. The result register lets the next request in while a result
// waits; a held result only stalls the following sample in its OUT state.
// After reset the block clears both RAMs, one ring entry per cycle, and
// accepts no request until done; register writes are taken during that time.
`include "assert_macros.svh"

module multichannel_slewed_fractional_delay
  import msfd_pkg::*;
#(
  parameter int CHANNELS   = 32,
  parameter int RING_DEPTH = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  msfd_req_if.sink          req_i,
  msfd_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int RW           = $clog2(RING_DEPTH);
  localparam int DW           = (RW > 13) ? RW : 13;
  localparam int CH_AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RING_ENTRIES = CHANNELS * RING_DEPTH;
  localparam int RING_AW      = $clog2(RING_ENTRIES);

  // Configuration registers
  cfg_t cfg;

  msfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Control state
  state_e               state_q, state_d;
  logic                 clear_q;
  logic [RING_AW-1:0]   clr_cnt_q;
  logic [RW-1:0]        widx_q;
  logic                 out_valid_q;

  // Request held for the duration of its processing
  logic [TYPE_W-1:0]          type_q;
  logic [CHAN_W-1:0]          ch_q;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [DVAL_W-1:0]          dval_q;
  logic [GAIN_W-1:0]          gval_q;
  logic                       fend_q;

  // Datapath registers
  logic [RW-1:0]              tap1_q;
  logic                       fwd0_q, fwd1_q;
  logic signed [48:0]         prod_w_q;
  logic signed [SAMPLE_W-1:0] wval_q;
  logic signed [SAMPLE_W-1:0] s0_q;
  logic signed [41:0]         prod_i_q;
  logic signed [50:0]         prod_o_q;
  logic [CHAN_W-1:0]          out_ch_q;
  logic signed [SAMPLE_W-1:0] out_smp_q;
  logic                       out_fend_q;

  // RAM ports
  logic               chan_we, chan_re;
  logic [CH_AW-1:0]   chan_waddr, chan_raddr;
  chan_state_t        chan_wdata, chan_rdata;
  logic               ring_we, ring_re;
  logic [RING_AW-1:0] ring_waddr, ring_raddr;
  logic [SAMPLE_W-1:0] ring_wdata, ring_rdata;

  msfd_ram #(
    .WIDTH ($bits(chan_state_t)),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (chan_we),
    .waddr_i (chan_waddr),
    .wdata_i (chan_wdata),
    .re_i    (chan_re),
    .raddr_i (chan_raddr),
    .rdata_o (chan_rdata)
  );

  msfd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_ENTRIES)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Request handshake and decode
  logic req_fire, in_ch_ok, in_type_ok, out_free, widx_adv;

  assign req_i.ready = (state_q == ST_IDLE) && !clear_q;
  assign req_fire    = req_i.valid && req_i.ready;
  assign in_ch_ok    = int'(req_i.channel) < CHANNELS;
  assign in_type_ok  = (req_i.req_type == REQ_SAMPLE) || (req_i.req_type == REQ_TRIM) ||
                       (req_i.req_type == REQ_TARGET);
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Frame boundary: after an ignored sample or at the end of a real one
  assign widx_adv = (req_fire && (req_i.req_type == REQ_SAMPLE) && !in_ch_ok &&
                     req_i.frame_end) || ((state_q == ST_INTERP) && fend_q);

  // Read taps: total delay = static + integer part of tracked delay
  logic [12:0]        di;
  logic [DW-1:0]      tap_diff;
  logic [RW-1:0]      tap0, tap1;
  logic [RING_AW-1:0] ring_base;

  assign di        = 13'(chan_rdata.static_delay) + 13'(chan_rdata.extra_now[27:16]);
  assign tap_diff  = DW'(widx_q) - DW'(di);
  assign tap0      = tap_diff[RW-1:0];
  assign tap1      = tap0 - RW'(1);
  assign ring_base = RING_AW'(ch_q) << RW;

  // Scaled input sample, rounded and saturated
  logic signed [48:0] wsum;
  logic signed [SAMPLE_W-1:0] wval;

  assign wsum = prod_w_q + 49'sd2097152;
  assign wval = sat24(64'(wsum >>> 22));

  // Linear interpolation between the two taps
  logic signed [SAMPLE_W-1:0] s1;
  logic signed [24:0]         tap_delta;
  logic signed [16:0]         frac;
  logic signed [41:0]         isum;
  logic signed [25:0]         interp;
  logic signed [24:0]         track_gain;

  assign s1         = fwd1_q ? wval_q : $signed(ring_rdata);
  assign tap_delta  = 25'(s1) - 25'(s0_q);
  assign frac       = $signed({1'b0, chan_rdata.extra_now[15:0]});
  assign isum       = prod_i_q + 42'sd32768;
  assign interp     = 26'(isum >>> 16) + 26'(s0_q);
  assign track_gain = $signed({1'b0, chan_rdata.gain_now});

  // Output rounding and saturation
  logic signed [50:0]         osum;
  logic signed [SAMPLE_W-1:0] oval;

  assign osum = prod_o_q + 51'sd2097152;
  assign oval = sat24(64'(osum >>> 22));

  // Slewed tracking state
  logic signed [29:0] ext_glide, gain_glide;
  logic [GAIN_W-1:0]  gain_now_next;

  assign ext_glide  = glide($signed({2'b00, chan_rdata.extra_now}),
                            $signed({2'b00, chan_rdata.extra_goal}),
                            $signed({14'b0, cfg.delay_slew_step}));
  assign gain_glide = glide($signed({6'b0, chan_rdata.gain_now}),
                            $signed({6'b0, chan_rdata.gain_goal}),
                            $signed({14'b0, cfg.gain_slew_step}));
  assign gain_now_next = gain_glide[GAIN_W-1:0];

  // Target clamps
  logic [DVAL_W-1:0] delay_ceil;
  assign delay_ceil = DVAL_W'({cfg.max_extra_delay, 16'b0});

  // Channel-state RAM port control
  always_comb begin
    chan_re    = req_fire;
    chan_raddr = CH_AW'(req_i.channel);
    chan_we    = 1'b0;
    chan_waddr = CH_AW'(ch_q);
    chan_wdata = chan_rdata;
    if (clear_q) begin
      chan_we    = clr_cnt_q < RING_AW'(CHANNELS);
      chan_waddr = CH_AW'(clr_cnt_q);
      chan_wdata = CHAN_RESET;
    end else if (state_q == ST_CHAN) begin
      if (type_q == REQ_TRIM) begin
        chan_we                 = 1'b1;
        chan_wdata.static_gain  = gval_q;
        chan_wdata.static_delay = (dval_q > DVAL_W'(STATIC_DELAY_MAX)) ?
                                  STATIC_DELAY_MAX : dval_q[SDLY_W-1:0];
      end else if (type_q == REQ_TARGET) begin
        chan_we               = 1'b1;
        chan_wdata.extra_goal = (dval_q > delay_ceil) ? delay_ceil : dval_q;
        if (gval_q < GAIN_MIN) begin
          chan_wdata.gain_goal = GAIN_MIN;
        end else if (gval_q > GAIN_MAX) begin
          chan_wdata.gain_goal = GAIN_MAX;
        end else begin
          chan_wdata.gain_goal = gval_q;
        end
      end
    end else if (state_q == ST_INTERP) begin
      chan_we              = 1'b1;
      chan_wdata.extra_now = ext_glide[DVAL_W-1:0];
      chan_wdata.gain_now  = gain_now_next;
    end
  end

  // Ring RAM port control: tap0 read, then tap1 read with the new sample write
  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = ring_base | RING_AW'(widx_q);
    ring_wdata = wval;
    ring_re    = 1'b0;
    ring_raddr = ring_base | RING_AW'(tap0);
    if (clear_q) begin
      ring_we    = 1'b1;
      ring_waddr = clr_cnt_q;
      ring_wdata = '0;
    end else if (state_q == ST_CHAN) begin
      ring_re = (type_q == REQ_SAMPLE);
    end else if (state_q == ST_TAP0) begin
      ring_we    = 1'b1;
      ring_re    = 1'b1;
      ring_raddr = ring_base | RING_AW'(tap1_q);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire && in_ch_ok && in_type_ok) begin
          state_d = ST_CHAN;
        end
      end
      ST_CHAN:   state_d = (type_q == REQ_SAMPLE) ? ST_TAP0 : ST_IDLE;
      ST_TAP0:   state_d = ST_TAP1;
      ST_TAP1:   state_d = ST_INTERP;
      ST_INTERP: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clear_q     <= 1'b1;
      clr_cnt_q   <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_q) begin
        clr_cnt_q <= clr_cnt_q + RING_AW'(1);
        if (clr_cnt_q == RING_AW'(RING_ENTRIES - 1)) begin
          clear_q <= 1'b0;
        end
      end
      if (widx_adv) begin
        widx_q <= widx_q + RW'(1);
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      type_q <= req_i.req_type;
      ch_q   <= req_i.channel;
      smp_q  <= req_i.sample_in;
      dval_q <= req_i.delay_value;
      gval_q <= req_i.gain_value;
      fend_q <= req_i.frame_end;
    end
    if (state_q == ST_CHAN) begin
      tap1_q   <= tap1;
      fwd0_q   <= (tap0 == widx_q);
      fwd1_q   <= (tap1 == widx_q);
      prod_w_q <= 49'(smp_q) * $signed({1'b0, chan_rdata.static_gain});
    end
    // A tap on the write slot sees the sample being written now
    if (state_q == ST_TAP0) begin
      wval_q <= wval;
      s0_q   <= fwd0_q ? wval : $signed(ring_rdata);
    end
    if (state_q == ST_TAP1) begin
      prod_i_q <= 42'(tap_delta) * 42'(frac);
    end
    if (state_q == ST_INTERP) begin
      prod_o_q <= 51'(interp) * 51'(track_gain);
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_ch_q   <= ch_q;
      out_smp_q  <= oval;
      out_fend_q <= fend_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.out_channel   = out_ch_q;
  assign rsp_o.out_sample    = out_smp_q;
  assign rsp_o.out_frame_end = out_fend_q;

  // The clearing pass never overlaps request processing
  `MSFD_ASSERT(a_clear_idle, clear_q |-> (state_q == ST_IDLE))
  // Write index moves only on a frame boundary event
  `MSFD_ASSERT(a_widx_step, (widx_q != $past(widx_q)) |-> ($past(state_q) == ST_INTERP || $past(req_fire)))
  // Tracked gain never leaves the target range
  `MSFD_ASSERT(a_gain_range, (state_q == ST_INTERP) |-> (gain_now_next >= GAIN_MIN && gain_now_next <= GAIN_MAX))

endmodule

// ----- rtl/msfd_ram.sv -----
// Simple dual-port RAM, one write and one registered read port.
// A read of the address being written returns the old contents.
module msfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/msfd_cfg.sv -----
// APB register file: extra-delay ceiling and the two slew steps
module msfd_cfg
  import msfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic        wr_en;
  logic [1:0]  reg_idx;
  logic [STEP_W-1:0] dstep_wr;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = paddr[3:2];
  assign dstep_wr = pwdata[STEP_W-1:0];

  // Write decode; a zero delay step is dropped, large ones saturate
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MAX_EXTRA: cfg_d.max_extra_delay = pwdata[SDLY_W-1:0];
        REG_DELAY_STEP: begin
          if (dstep_wr != '0) begin
            cfg_d.delay_slew_step = (dstep_wr > DSTEP_MAX) ? DSTEP_MAX : dstep_wr;
          end
        end
        REG_GAIN_STEP: cfg_d.gain_slew_step = pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_extra_delay <= MAX_EXTRA_RST;
      cfg_q.delay_slew_step <= DELAY_STEP_RST;
      cfg_q.gain_slew_step  <= GAIN_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_MAX_EXTRA:  prdata = CFG_DW'(cfg_q.max_extra_delay);
      REG_DELAY_STEP: prdata = CFG_DW'(cfg_q.delay_slew_step);
      REG_GAIN_STEP:  prdata = CFG_DW'(cfg_q.gain_slew_step);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
